FILE: hdl/bti_pkg.sv
package bti_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int DATA_W      = 32;
	localparam int CFG_IDX_W   = 3;

	localparam int DIV_NUM_W = 64;
	localparam int DIV_DEN_W = 32;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_EVAL   = 2'd2;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_EMPTY    = 2'd1;
	localparam logic [1:0] STAT_NOT_ASC  = 2'd2;
	localparam logic [1:0] STAT_FULL     = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_X_SPAN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_V_FLOOR  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_V_SPAN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 3'd5;

	typedef struct packed {
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
	} point_t;

endpackage

FILE: hdl/bti_if.sv
interface bti_cmd_if;
	logic              valid;
	logic              ready;
	logic [1:0]        command;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] ratio;

	modport source (output valid, command, point_x, point_y, ratio, input ready);
	modport sink (input valid, command, point_x, point_y, ratio, output ready);
endinterface

interface bti_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] curve_value;
	logic signed [15:0] rounded_value;
	logic [1:0]         status;

	modport source (output valid, curve_value, rounded_value, status, input ready);
	modport sink (input valid, curve_value, rounded_value, status, output ready);
endinterface

FILE: hdl/bti_table_ram.sv
module bti_table_ram (
	input  logic                       clk,
	input  logic                       we,
	input  logic [bti_pkg::ADDR_W-1:0] waddr,
	input  bti_pkg::point_t            wdata,
	input  logic [bti_pkg::ADDR_W-1:0] raddr,
	output bti_pkg::point_t            rdata
);

	bti_pkg::point_t mem [bti_pkg::TABLE_DEPTH];

	// write one breakpoint
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/bti_divider.sv
module bti_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [bti_pkg::DIV_NUM_W-1:0] num,
	input  logic [bti_pkg::DIV_DEN_W-1:0] den,
	output logic                          done,
	output logic [bti_pkg::DIV_NUM_W-1:0] quo
);

	logic [bti_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          done_q;
	logic [bti_pkg::DIV_NUM_W-1:0] quo_q;
	logic [bti_pkg::DIV_DEN_W-1:0] rem_q;
	logic [bti_pkg::DIV_DEN_W-1:0] den_q;
	logic [bti_pkg::DIV_DEN_W:0]   rem_sh;
	logic [bti_pkg::DIV_DEN_W:0]   rem_sub;
	logic                          fits;

	// one restoring step: shift in the next dividend bit, try subtract
	always_comb begin
		rem_sh  = {rem_q, quo_q[bti_pkg::DIV_NUM_W-1]};
		rem_sub = rem_sh - {1'b0, den_q};
		fits    = rem_sh >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == bti_pkg::DIV_CNT_W'(1));
			if (start) begin
				cnt_q <= bti_pkg::DIV_CNT_W'(bti_pkg::DIV_NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[bti_pkg::DIV_NUM_W-2:0], fits};
			rem_q <= fits ? rem_sub[bti_pkg::DIV_DEN_W-1:0] : rem_sh[bti_pkg::DIV_DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

FILE: hdl/breakpoint_table_interpolator_unit.sv
// Piecewise linear interpolation over a table of up to TABLE_DEPTH Q16.16
// breakpoints held in a one-port-write, one-port-read synchronous memory.
// Commands enter on req one at a time and each gives one beat on rsp. An
// append to a non-empty, non-full table first checks its x against the last
// stored x. An evaluate runs a binary search of at most ceil(log2(count+1))
// steps, each one memory read and one compare, unless the table is empty.
// An interpolating evaluate makes two passes of the shared 64-step restoring
// divider (segment fraction, then value scaling); one whose sample lies
// outside the table, or on an empty table, makes only the scaling pass.
// A finished beat waits in the output register; a stalled receiver holds the
// block until that register frees. Configuration registers are written
// through cfg_we/cfg_index/cfg_data; the user must write them only while the
// block is idle, and the block itself does not enforce it.
module breakpoint_table_interpolator_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bti_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bti_pkg::DATA_W-1:0]    cfg_data,
	bti_cmd_if.sink                       req,
	bti_res_if.source                     rsp
);

	typedef enum logic [15:0] {
		S_IDLE     = 16'h0001,
		S_APP_CHK  = 16'h0002,
		S_XQ       = 16'h0004,
		S_SRCH     = 16'h0008,
		S_SRCH_CMP = 16'h0010,
		S_PICK     = 16'h0020,
		S_CLAMP    = 16'h0040,
		S_SEG0     = 16'h0080,
		S_SEG1     = 16'h0100,
		S_DIVT     = 16'h0200,
		S_INTERP   = 16'h0400,
		S_SCALE    = 16'h0800,
		S_SDIV0    = 16'h1000,
		S_SDIV     = 16'h2000,
		S_FIN      = 16'h4000,
		S_OUT      = 16'h8000
	} state_t;

	state_t state_q;

	// configuration
	logic signed [31:0] x_origin_q, x_span_q, v_floor_q, v_span_q, offset_q, gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_origin_q <= '0;
			x_span_q   <= 32'sd65536;
			v_floor_q  <= '0;
			v_span_q   <= 32'sd65536;
			offset_q   <= '0;
			gain_q     <= 32'sd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				bti_pkg::CFG_X_ORIGIN: x_origin_q <= cfg_data;
				bti_pkg::CFG_X_SPAN:   x_span_q   <= cfg_data;
				bti_pkg::CFG_V_FLOOR:  v_floor_q  <= cfg_data;
				bti_pkg::CFG_V_SPAN:   v_span_q   <= cfg_data;
				bti_pkg::CFG_OFFSET:   offset_q   <= cfg_data;
				bti_pkg::CFG_GAIN:     gain_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// command latch and datapath registers
	logic signed [31:0]             px_q, py_q, ratio_q;
	logic [bti_pkg::CNT_W-1:0]      cnt_q, lo_q, hi_q, mid_q;
	logic signed [63:0]             xq_q;
	bti_pkg::point_t                p0_q;
	bti_pkg::point_t                p1_q;
	logic [15:0]                    t_q;
	logic signed [31:0]             v_q;
	logic [63:0]                    prod_q;
	logic [31:0]                    sm_q;
	logic                           neg_q;
	logic signed [31:0]             curve_q;
	logic signed [31:0]             res_curve_q;
	logic signed [15:0]             res_rnd_q;
	logic [1:0]                     res_stat_q;
	logic                           out_vld_q;
	logic signed [31:0]             out_curve_q;
	logic signed [15:0]             out_rnd_q;
	logic [1:0]                     out_stat_q;

	// memory and divider hookup
	logic                           ram_we;
	logic [bti_pkg::ADDR_W-1:0]     ram_raddr;
	bti_pkg::point_t                ram_wdata, ram_rdata;
	logic                           div_start, div_done;
	logic [63:0]                    div_num, div_quo;
	logic [31:0]                    div_den;

	bti_table_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[bti_pkg::ADDR_W-1:0]),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bti_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	logic                       accept;
	logic [bti_pkg::CNT_W-1:0]  mid, cnt_m1, lo_m1;
	logic signed [63:0]         xr_prod, xq_new, rd_x_sh, p0_x_sh;
	logic signed [32:0]         seg_dx;
	logic signed [32:0]         dy;
	logic signed [49:0]         ty_prod;
	logic signed [33:0]         v_new;
	logic signed [32:0]         d_val;
	logic [32:0]                dm;
	logic [31:0]                gm, sm;
	logic signed [42:0]         q_signed, sum43;
	logic signed [31:0]         curve_new;
	logic [32:0]                c_mag;
	logic [16:0]                c_rnd;
	logic signed [15:0]         rnd_new;
	logic                       app_ok_idle;

	assign accept  = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);

	// address and arithmetic helpers
	always_comb begin
		mid     = lo_q + ((hi_q - lo_q) >> 1);
		cnt_m1  = cnt_q - 1'b1;
		lo_m1   = lo_q - 1'b1;
		xr_prod = ratio_q * x_span_q;
		xq_new  = {{16{x_origin_q[31]}}, x_origin_q, 16'd0} + xr_prod;
		rd_x_sh = {{16{ram_rdata.x[31]}}, ram_rdata.x, 16'd0};
		p0_x_sh = {{16{p0_q.x[31]}}, p0_q.x, 16'd0};
		seg_dx  = {ram_rdata.x[31], ram_rdata.x} - {p0_q.x[31], p0_q.x};
		dy      = {p1_q.y[31], p1_q.y} - {p0_q.y[31], p0_q.y};
		ty_prod = $signed({1'b0, t_q}) * dy;
		v_new   = {{2{p0_q.y[31]}}, p0_q.y} + 34'(ty_prod >>> 16);
		d_val   = {v_q[31], v_q} - {v_floor_q[31], v_floor_q};
		dm      = d_val[32] ? 33'(-d_val) : 33'(d_val);
		gm      = gain_q[31] ? 32'(-gain_q) : 32'(gain_q);
		sm      = (v_span_q == '0) ? 32'd1 : (v_span_q[31] ? 32'(-v_span_q) : 32'(v_span_q));
		q_signed = neg_q ? -$signed({1'b0, div_quo[41:0]}) : $signed({1'b0, div_quo[41:0]});
		sum43   = {{11{offset_q[31]}}, offset_q} + q_signed;
		if (div_quo > 64'h0000_0100_0000_0000) begin
			curve_new = neg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else if (sum43 > 43'sh7FFF_FFFF) begin
			curve_new = 32'sh7FFF_FFFF;
		end else if (sum43 < -43'sh8000_0000) begin
			curve_new = 32'sh8000_0000;
		end else begin
			curve_new = sum43[31:0];
		end
		c_mag = curve_q[31] ? 33'(-{curve_q[31], curve_q}) : {1'b0, curve_q};
		c_rnd = 17'((c_mag + 33'd32768) >> 16);
		if (curve_q[31]) begin
			rnd_new = 16'(-$signed(c_rnd));
		end else begin
			rnd_new = (c_rnd > 17'd32767) ? 16'sd32767 : c_rnd[15:0];
		end
	end

	// memory read address per state
	always_comb begin
		case (state_q)
			S_IDLE: ram_raddr = cnt_m1[bti_pkg::ADDR_W-1:0];
			S_SRCH: ram_raddr = mid[bti_pkg::ADDR_W-1:0];
			S_PICK: begin
				if (lo_q == '0) ram_raddr = '0;
				else if (lo_q >= cnt_q) ram_raddr = cnt_m1[bti_pkg::ADDR_W-1:0];
				else ram_raddr = lo_m1[bti_pkg::ADDR_W-1:0];
			end
			S_SEG0: ram_raddr = lo_q[bti_pkg::ADDR_W-1:0];
			default: ram_raddr = '0;
		endcase
	end

	// write a breakpoint on an empty-table append or when the ascending check passes
	always_comb begin
		app_ok_idle = accept && (req.command == bti_pkg::CMD_APPEND) && (cnt_q == '0);
		ram_we      = app_ok_idle || ((state_q == S_APP_CHK) && (px_q > ram_rdata.x));
		ram_wdata.x = (state_q == S_IDLE) ? req.point_x : px_q;
		ram_wdata.y = (state_q == S_IDLE) ? req.point_y : py_q;
	end

	// divider operands: segment fraction, then value scaling
	always_comb begin
		div_start = (state_q == S_SEG1) || (state_q == S_SDIV0);
		if (state_q == S_SEG1) begin
			div_num = 64'(xq_q - p0_x_sh);
			div_den = seg_dx[31:0];
		end else begin
			div_num = prod_q;
			div_den = sm_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.command)
							bti_pkg::CMD_CLEAR: begin
								cnt_q   <= '0;
								state_q <= S_OUT;
							end
							bti_pkg::CMD_APPEND: begin
								if (cnt_q >= bti_pkg::CNT_W'(bti_pkg::TABLE_DEPTH)) begin
									state_q <= S_OUT;
								end else if (cnt_q == '0) begin
									cnt_q   <= cnt_q + 1'b1;
									state_q <= S_OUT;
								end else begin
									state_q <= S_APP_CHK;
								end
							end
							bti_pkg::CMD_EVAL: begin
								state_q <= (cnt_q == '0) ? S_SCALE : S_XQ;
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_APP_CHK: begin
					if (px_q > ram_rdata.x) cnt_q <= cnt_q + 1'b1;
					state_q <= S_OUT;
				end
				S_XQ:       state_q <= S_SRCH;
				S_SRCH:     state_q <= (lo_q < hi_q) ? S_SRCH_CMP : S_PICK;
				S_SRCH_CMP: state_q <= S_SRCH;
				S_PICK: begin
					if (lo_q == '0 || lo_q >= cnt_q) state_q <= S_CLAMP;
					else state_q <= S_SEG0;
				end
				S_CLAMP:    state_q <= S_SCALE;
				S_SEG0:     state_q <= S_SEG1;
				S_SEG1:     state_q <= S_DIVT;
				S_DIVT:     if (div_done) state_q <= S_INTERP;
				S_INTERP:   state_q <= S_SCALE;
				S_SCALE:    state_q <= S_SDIV0;
				S_SDIV0:    state_q <= S_SDIV;
				S_SDIV:     if (div_done) state_q <= S_FIN;
				S_FIN:      state_q <= S_OUT;
				S_OUT: begin
					if (!out_vld_q || rsp.ready) state_q <= S_IDLE;
				end
				default:    state_q <= S_IDLE;
			endcase
		end
	end

	// raise valid when a beat is loaded, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == S_OUT && (!out_vld_q || rsp.ready)) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					px_q        <= req.point_x;
					py_q        <= req.point_y;
					ratio_q     <= req.ratio;
					res_curve_q <= '0;
					res_rnd_q   <= '0;
					v_q         <= '0;
					if (req.command == bti_pkg::CMD_APPEND &&
					    cnt_q >= bti_pkg::CNT_W'(bti_pkg::TABLE_DEPTH)) begin
						res_stat_q <= bti_pkg::STAT_FULL;
					end else if (req.command == bti_pkg::CMD_EVAL && cnt_q == '0) begin
						res_stat_q <= bti_pkg::STAT_EMPTY;
					end else begin
						res_stat_q <= bti_pkg::STAT_OK;
					end
				end
			end
			S_APP_CHK: begin
				if (!(px_q > ram_rdata.x)) res_stat_q <= bti_pkg::STAT_NOT_ASC;
			end
			S_XQ: begin
				xq_q <= xq_new;
				lo_q <= '0;
				hi_q <= cnt_q;
			end
			S_SRCH: mid_q <= mid;
			S_SRCH_CMP: begin
				// narrow toward the first breakpoint beyond the sample
				if (rd_x_sh > xq_q) hi_q <= mid_q;
				else lo_q <= mid_q + 1'b1;
			end
			S_CLAMP: v_q <= ram_rdata.y;
			S_SEG0:  p0_q <= ram_rdata;
			S_SEG1:  ;
			S_DIVT: begin
				if (div_done) t_q <= (|div_quo[63:16]) ? 16'hFFFF : div_quo[15:0];
			end
			default: ;
		endcase
		// store the interpolated value in the interpolation step
		if (state_q == S_INTERP) v_q <= v_new[31:0];
		if (state_q == S_SCALE) begin
			prod_q <= 64'(dm * gm);
			sm_q   <= sm;
			neg_q  <= d_val[32] ^ gain_q[31] ^ ((v_span_q != '0) && v_span_q[31]);
		end
		if (state_q == S_SDIV && div_done) curve_q <= curve_new;
		if (state_q == S_FIN) begin
			res_curve_q <= curve_q;
			res_rnd_q   <= rnd_new;
		end
		// load the output beat
		if (state_q == S_OUT && (!out_vld_q || rsp.ready)) begin
			out_curve_q <= res_curve_q;
			out_rnd_q   <= res_rnd_q;
			out_stat_q  <= res_stat_q;
		end
	end

	// second segment end point comes straight from the memory during S_SEG1;
	// keep it for the interpolation step
	always_ff @(posedge clk) begin
		if (state_q == S_SEG1) p1_q <= ram_rdata;
	end

	assign rsp.valid         = out_vld_q;
	assign rsp.curve_value   = out_curve_q;
	assign rsp.rounded_value = out_rnd_q;
	assign rsp.status        = out_stat_q;

endmodule
